/* design/bdpc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants for the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

    localparam int DebounceW = 8;
    localparam int HoldW     = 16;
    localparam int BlinkW    = 16;
    localparam int CfgDataW  = 16;
    localparam int CfgIdxW   = 2;

    localparam logic [DebounceW-1:0] DebounceMax   = '1;
    localparam logic [HoldW-1:0]     HoldMax       = '1;

    localparam logic [DebounceW-1:0] DebounceReset = 8'd5;
    localparam logic [HoldW-1:0]     LongReset     = 16'd100;
    localparam logic [BlinkW-1:0]    BlinkReset    = 16'd10;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_LONG     = 2'd1,
        CFG_BLINK    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_ON    = 2'd1,
        MODE_BLINK = 2'd2
    } t_led_mode;

    typedef struct packed {
        logic short_press;
        logic long_press;
    } t_press_evt;

endpackage
`default_nettype wire

/* design/bdpc_debounce.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdpc_debounce
// Debounce state, accepted level, hold counter and press classification.
// ----------------------------------------------------------------------------
module bdpc_debounce (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_step,
    input  wire logic                            i_btn_raw,
    input  wire logic                            i_edge_seen,
    input  wire logic [bdpc_pkg::DebounceW-1:0]  i_settle_ticks,
    input  wire logic [bdpc_pkg::HoldW-1:0]      i_long_press_ticks,
    output logic                                 o_level,
    output bdpc_pkg::t_press_evt                 o_evt
);
    import bdpc_pkg::*;

    logic                 r_armed;
    logic [DebounceW-1:0] r_count;
    logic                 r_level;
    logic [HoldW-1:0]     r_hold;

    logic                 n_armed;
    logic [DebounceW-1:0] n_count;
    logic                 n_level;
    logic [HoldW-1:0]     n_hold;

    logic                 armed0;
    logic [DebounceW-1:0] count0;
    logic [DebounceW-1:0] count1;
    logic [HoldW-1:0]     hold1;

    always_comb begin
        armed0 = i_edge_seen | r_armed;
        count0 = i_edge_seen ? '0 : r_count;
        count1 = (count0 < DebounceMax) ? count0 + 1'b1 : count0;
        n_armed = armed0;
        n_count = count0;
        n_level = r_level;
        hold1   = r_hold;
        o_evt   = '0;
        if (armed0) begin
            if (i_btn_raw == r_level) begin
                n_armed = 1'b0;
                n_count = '0;
            end else if (count1 >= i_settle_ticks) begin
                n_level = i_btn_raw;
                n_armed = 1'b0;
                n_count = '0;
                // release after a nonzero hold gives one event
                if (!i_btn_raw && r_hold != '0) begin
                    o_evt.short_press = (r_hold < i_long_press_ticks);
                    o_evt.long_press  = (r_hold >= i_long_press_ticks);
                end
                hold1 = '0;
            end else begin
                n_count = count1;
            end
        end
        n_hold = (n_level && hold1 < HoldMax) ? hold1 + 1'b1 : hold1;
        o_level = n_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_count <= '0;
            r_level <= 1'b0;
            r_hold  <= '0;
        end else if (i_step) begin
            r_armed <= n_armed;
            r_count <= n_count;
            r_level <= n_level;
            r_hold  <= n_hold;
        end
    end

endmodule
`default_nettype wire

/* design/bdpc_led_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdpc_led_ctrl
// Three-mode LED controller: mode stepping on press events and blink timer.
// ----------------------------------------------------------------------------
module bdpc_led_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_step,
    input  wire bdpc_pkg::t_press_evt         i_evt,
    input  wire logic [bdpc_pkg::BlinkW-1:0]  i_blink_ticks,
    output bdpc_pkg::t_led_mode               o_mode,
    output logic                              o_led
);
    import bdpc_pkg::*;

    t_led_mode         r_mode;
    logic [BlinkW-1:0] r_blink;
    logic              r_led;

    t_led_mode         n_mode;
    logic [BlinkW-1:0] n_blink;
    logic              n_led;

    logic [BlinkW-1:0] blink1;
    logic              toggle;

    always_comb begin
        blink1  = r_blink + 1'b1;
        toggle  = 1'b0;
        n_blink = '0;
        if (r_mode == MODE_BLINK) begin
            if (blink1 >= i_blink_ticks) begin
                toggle = 1'b1;
            end else begin
                n_blink = blink1;
            end
        end

        n_mode = r_mode;
        n_led  = r_led;
        if (i_evt.short_press) begin
            unique case (r_mode)
                MODE_OFF: begin
                    n_mode = MODE_ON;
                    n_led  = 1'b1;
                end
                MODE_ON: begin
                    n_mode = MODE_BLINK;
                end
                default: begin
                    n_mode = MODE_OFF;
                    n_led  = 1'b0;
                end
            endcase
        end
        if (i_evt.long_press) begin
            n_mode = MODE_OFF;
            n_led  = 1'b0;
        end
        // toggle dropped when the mode left blink this tick
        if (toggle && n_mode == MODE_BLINK) begin
            n_led = ~n_led;
        end
        o_mode = n_mode;
        o_led  = n_led;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_OFF;
            r_blink <= '0;
            r_led   <= 1'b0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_blink <= n_blink;
            r_led   <= n_led;
        end
    end

endmodule
`default_nettype wire

/* design/button_debounce_press_classifier_top.sv */
`default_nettype none
// A result beat is valid once its accepted input beat has passed the input
// register, taken at the accepting edge, and then the result register.
// Throughput: one tick per clock without receiver stalls; a tick's update is
// one pass of counter and compare logic between input and result registers.
// Reset: synchronous, active low; clears valid flags, debounce and LED state
// and restores register defaults (debounce 5, long press 100, blink 10).
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_top
// Button debounce, short/long press classification and LED mode control.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [bdpc_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  wire logic [bdpc_pkg::CfgDataW-1:0]  i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_btn_raw,
    input  wire logic                           i_edge_seen,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic                                o_button_level,
    output logic                                o_short_press,
    output logic                                o_long_press,
    output logic [1:0]                          o_led_mode,
    output logic                                o_led_out
);
    import bdpc_pkg::*;

    logic [DebounceW-1:0] r_settle_ticks;
    logic [HoldW-1:0]     r_long_ticks;
    logic [BlinkW-1:0]    r_blink_ticks;

    logic r_in_valid;
    logic r_raw;
    logic r_edge;

    logic       r_out_valid;
    logic       r_level;
    t_press_evt r_evt;
    t_led_mode  r_mode;
    logic       r_led;

    logic       advance;
    logic       step;
    logic       level;
    t_press_evt evt;
    t_led_mode  mode;
    logic       led;

    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ticks <= DebounceReset;
            r_long_ticks   <= LongReset;
            r_blink_ticks  <= BlinkReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEBOUNCE: r_settle_ticks <= i_cfg_data[DebounceW-1:0];
                CFG_LONG:     r_long_ticks   <= i_cfg_data[HoldW-1:0];
                CFG_BLINK:    r_blink_ticks  <= i_cfg_data[BlinkW-1:0];
                default:      ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_raw  <= i_btn_raw;
            r_edge <= i_edge_seen;
        end
    end

    bdpc_debounce u_debounce (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (step),
        .i_btn_raw          (r_raw),
        .i_edge_seen        (r_edge),
        .i_settle_ticks     (r_settle_ticks),
        .i_long_press_ticks (r_long_ticks),
        .o_level            (level),
        .o_evt              (evt)
    );

    bdpc_led_ctrl u_led_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_evt         (evt),
        .i_blink_ticks (r_blink_ticks),
        .o_mode        (mode),
        .o_led         (led)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_level <= level;
            r_evt   <= evt;
            r_mode  <= mode;
            r_led   <= led;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_button_level = r_level;
    assign o_short_press  = r_evt.short_press;
    assign o_long_press   = r_evt.long_press;
    assign o_led_mode     = r_mode;
    assign o_led_out      = r_led;

endmodule
`default_nettype wire

/* dv/button_debounce_press_classifier_top_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_top_tb
// Drives timer ticks into the debounce and press classifier and compares
// every result beat with a tick-accurate predictor of the debouncer, the
// hold counter and the LED mode controller. Directed sequences cover
// the zero-valued registers, mode stepping and the dropped blink toggle.
// Random phases then run press sequences with bounce noise under changing
// register settings, sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_top_tb;
    import bdpc_pkg::*;

    localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;
    localparam int RxHoldCycles = 300;
    localparam int StallLimit   = 3000;
    localparam int PhaseTicks   = 140;
    localparam int ReportMax    = 10;

    typedef struct packed {
        logic      level;
        logic      short_evt;
        logic      long_evt;
        t_led_mode mode;
        logic      led;
    } t_tick_result;

    // predicts the result of every accepted tick and checks result beats
    class button_tick_scoreboard;
        logic [DebounceW-1:0] settle_ticks;
        logic [HoldW-1:0]     long_ticks;
        logic [BlinkW-1:0]    blink_ticks;
        logic                 armed;
        logic [DebounceW-1:0] debounce_cnt;
        logic                 level;
        logic [HoldW-1:0]     hold_cnt;
        logic [BlinkW-1:0]    blink_cnt;
        t_led_mode            mode;
        logic                 led;
        t_tick_result         expected_ticks[$];
        int                   failures;
        int                   results_seen;

        function new();
            settle_ticks   = DebounceReset;
            long_ticks     = LongReset;
            blink_ticks    = BlinkReset;
            armed          = 1'b0;
            debounce_cnt   = '0;
            level          = 1'b0;
            hold_cnt       = '0;
            blink_cnt      = '0;
            mode           = MODE_OFF;
            led            = 1'b0;
            failures       = 0;
            results_seen   = 0;
        endfunction

        function void write_reg(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] data);
            case (idx)
                CFG_DEBOUNCE: settle_ticks   = data[DebounceW-1:0];
                CFG_LONG:     long_ticks     = data[HoldW-1:0];
                CFG_BLINK:    blink_ticks    = data[BlinkW-1:0];
                default:      ;
            endcase
        endfunction

        function void note_tick(input logic raw, input logic edg);
            logic ev_short;
            logic ev_long;
            logic toggle;
            ev_short = 1'b0;
            ev_long  = 1'b0;
            toggle   = 1'b0;
            if (edg) begin
                armed        = 1'b1;
                debounce_cnt = '0;
            end
            if (armed) begin
                if (raw == level) begin
                    armed        = 1'b0;
                    debounce_cnt = '0;
                end else begin
                    if (debounce_cnt != DebounceMax) debounce_cnt = debounce_cnt + 1'b1;
                    if (debounce_cnt >= settle_ticks) begin
                        level        = raw;
                        armed        = 1'b0;
                        debounce_cnt = '0;
                        if (!level && hold_cnt != '0) begin
                            if (hold_cnt < long_ticks) ev_short = 1'b1;
                            else ev_long = 1'b1;
                        end
                        hold_cnt = '0;
                    end
                end
            end
            if (level && hold_cnt != HoldMax) hold_cnt = hold_cnt + 1'b1;
            // blink counter follows the mode held at the start of the tick
            if (mode == MODE_BLINK) begin
                blink_cnt = blink_cnt + 1'b1;
                if (blink_cnt >= blink_ticks) begin
                    blink_cnt = '0;
                    toggle    = 1'b1;
                end
            end else begin
                blink_cnt = '0;
            end
            if (ev_short) begin
                case (mode)
                    MODE_OFF: mode = MODE_ON;
                    MODE_ON:  mode = MODE_BLINK;
                    default:  mode = MODE_OFF;
                endcase
                if (mode == MODE_OFF) led = 1'b0;
                else if (mode == MODE_ON) led = 1'b1;
            end
            if (ev_long) begin
                mode = MODE_OFF;
                led  = 1'b0;
            end
            // toggle is dropped when the mode left blink this tick
            if (toggle && mode == MODE_BLINK) led = ~led;
            expected_ticks.push_back('{level, ev_short, ev_long, mode, led});
        endfunction

        function void check_tick_result(input t_tick_result got);
            t_tick_result want;
            results_seen++;
            if (expected_ticks.size() == 0) begin
                failures++;
                if (failures <= ReportMax)
                    $display("result beat %0d arrived with no tick pending", results_seen);
                return;
            end
            want = expected_ticks.pop_front();
            if (got.level !== want.level || got.short_evt !== want.short_evt ||
                got.long_evt !== want.long_evt || got.mode !== want.mode ||
                got.led !== want.led) begin
                failures++;
                if (failures <= ReportMax) begin
                    $display("result beat %0d mismatch: expected level=%0b short=%0b long=%0b mode=%0d led=%0b",
                             results_seen, want.level, want.short_evt, want.long_evt,
                             want.mode, want.led);
                    $display("    got level=%0b short=%0b long=%0b mode=%0d led=%0b",
                             got.level, got.short_evt, got.long_evt, got.mode, got.led);
                end
            end
        endfunction

        function void check_drained();
            if (expected_ticks.size() != 0) begin
                failures++;
                if (failures <= ReportMax)
                    $display("%0d result beats never arrived", expected_ticks.size());
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_btn_raw;
    logic                i_edge_seen;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_button_level;
    logic                o_short_press;
    logic                o_long_press;
    logic [1:0]          o_led_mode;
    logic                o_led_out;

    button_tick_scoreboard sb = new();
    logic [1:0] tick_q[$];      // {btn_raw, edge_seen}
    int  idle_cycles  = 0;
    int  rx_stall_pct = 0;
    bit  rx_hold_req  = 1'b0;

    button_debounce_press_classifier_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_btn_raw      (i_btn_raw),
        .i_edge_seen    (i_edge_seen),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_button_level (o_button_level),
        .o_short_press  (o_short_press),
        .o_long_press   (o_long_press),
        .o_led_mode     (o_led_mode),
        .o_led_out      (o_led_out)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_tick_result('{o_button_level, o_short_press, o_long_press,
                                   t_led_mode'(o_led_mode), o_led_out});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < StallLimit) @(posedge i_clk);
        $display("no beat moved for %0d cycles", StallLimit);
        $display("[button_debounce_press_classifier_top] ERROR");
        $finish;
    end

    // receiver: random ready runs, plus one long hold-off on request
    initial begin : receiver
        int run;
        run = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (RxHoldCycles) @(posedge i_clk);
                rx_hold_req = 1'b0;
                i_out_ready <= 1'b1;
            end else if (run > 0) begin
                run--;
            end else if ($urandom_range(0, 99) >= rx_stall_pct) begin
                i_out_ready <= 1'b1;
                run = $urandom_range(0, 7);
            end else begin
                i_out_ready <= 1'b0;
                run = $urandom_range(0, 5);
            end
        end
    end

    task automatic push_tick(input logic raw, input logic edg);
        tick_q.push_back({raw, edg});
    endtask

    task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // upper byte of the debounce write and the unused index carry junk
    task automatic apply_config(input logic [DebounceW-1:0] deb, input logic [HoldW-1:0] lng,
                                input logic [BlinkW-1:0] blk);
        cfg_write(CFG_DEBOUNCE, {8'($urandom), deb});
        cfg_write(CFG_LONG, lng);
        cfg_write(CFG_BLINK, blk);
        cfg_write(CfgIdxUnused, 16'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // sends the queued ticks in bursts; max_gap of zero keeps valid high throughout
    task automatic drive_ticks(input int max_gap);
        logic [1:0] item;
        int burst;
        burst = $urandom_range(1, 24);
        while (tick_q.size() > 0) begin
            item = tick_q.pop_front();
            i_in_valid  <= 1'b1;
            i_btn_raw   <= item[1];
            i_edge_seen <= item[0];
            do @(posedge i_clk); while (!o_in_ready);
            sb.note_tick(item[1], item[0]);
            burst--;
            if (tick_q.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (burst <= 0 && max_gap > 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, max_gap)) @(posedge i_clk);
                burst = $urandom_range(1, 24);
            end
        end
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (sb.expected_ticks.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // press, hold, release, then rest; duration spread around the long threshold
    task automatic gen_press(input int deb, input int lng);
        int dur;
        if ($urandom_range(0, 1)) dur = $urandom_range(0, deb + lng);
        else dur = $urandom_range(0, deb + 2 * lng + 2);
        push_tick(1'b1, 1'b1);
        repeat (dur) push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);
        repeat ($urandom_range(deb, deb + 6)) push_tick(1'b0, 1'b0);
    endtask

    initial begin : stimulus
        int phase;
        int deb;
        int lng;
        int blk;
        int gap;
        int pick;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_DEBOUNCE;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_btn_raw   <= 1'b0;
        i_edge_seen <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: all input combinations, matching level disarms
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b0);
        drive_ticks(3);
        wait_idle();

        // zero debounce and zero long threshold: every release is long
        apply_config(8'd0, 16'd0, 16'd0);
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);
        drive_ticks(3);
        wait_idle();

        // step off -> on -> blink, toggle every tick, leave blink, then a long press
        apply_config(8'd0, 16'd3, 16'd0);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);
        repeat (3) push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b1);
        repeat (3) push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);
        drive_ticks(0);
        wait_idle();

        for (phase = 0; phase < 8; phase++) begin
            deb = $urandom_range(0, 4);
            lng = $urandom_range(1, 24);
            blk = $urandom_range(0, 6);
            gap = (phase % 3 == 0) ? 0 : $urandom_range(2, 12);
            rx_stall_pct = (phase % 4 == 1) ? 0 : $urandom_range(20, 70);
            case (phase)
                0: begin
                    deb = 1;
                    lng = 1;
                    blk = 1;
                end
                5: begin
                    deb = 0;
                    lng = 0;
                    blk = 0;
                end
                default: ;
            endcase
            if (phase == 2) begin
                // widest settings: one press that needs the full debounce count
                apply_config(8'd255, 16'hFFFF, 16'hFFFF);
                push_tick(1'b1, 1'b1);
                repeat (259) push_tick(1'b1, 1'b0);
                push_tick(1'b0, 1'b1);
                repeat (3) push_tick(1'b0, 1'b0);
            end else begin
                apply_config(8'(deb), 16'(lng), 16'(blk));
                while (tick_q.size() < PhaseTicks) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 7) begin
                        gen_press(deb, lng);
                    end else if (pick < 9) begin
                        repeat ($urandom_range(1, 6))
                            push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    end else begin
                        repeat ($urandom_range(1, 4)) push_tick(1'($urandom_range(0, 1)), 1'b0);
                    end
                end
            end
            if (phase == 4) begin
                gap = 0;
                rx_hold_req = 1'b1;
            end
            drive_ticks(gap);
            wait_idle();
        end

        sb.check_drained();
        if (sb.failures == 0) begin
            $display("[button_debounce_press_classifier_top] OK");
        end else begin
            $display("[button_debounce_press_classifier_top] ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
design/bdpc_pkg.sv
design/bdpc_debounce.sv
design/bdpc_led_ctrl.sv
design/button_debounce_press_classifier_top.sv
dv/button_debounce_press_classifier_top_tb.sv
